// ===== src/walsh_hadamard_xor_or_and_unit_defines.svh =====
// assertion macros for the walsh hadamard xor/or/and unit
`ifndef WALSH_HADAMARD_XOR_OR_AND_UNIT_DEFINES_SVH
`define WALSH_HADAMARD_XOR_OR_AND_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define WHXOA_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("whxoa assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define WHXOA_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("whxoa assertion failed");

`endif

// ===== src/whxoa_pkg.sv =====
// shared constants, types and helper functions of the walsh hadamard unit
`timescale 1ns / 1ps

package whxoa_pkg;

	localparam int MAX_LOG_SIZE = 6;
	localparam int SAMPLE_WIDTH = 32;
	localparam int SAMPLE_W     = 32;
	localparam int WORD_W       = 40;
	localparam int DEPTH        = 1 << MAX_LOG_SIZE;
	localparam int ADDR_W       = MAX_LOG_SIZE;
	localparam int CNT_W        = MAX_LOG_SIZE + 1;
	localparam int LOG_W        = 3;
	localparam int MODE_W       = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERSE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_SIZE = 2'd2;

	localparam logic [MODE_W-1:0] MODE_XOR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_OR  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_AND = 2'd2;

	localparam logic [LOG_W-1:0] LOG_SIZE_RST = 3'd6;
	localparam logic [LOG_W-1:0] MAX_LOG      = LOG_W'(MAX_LOG_SIZE);

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              inverse;
		logic [LOG_W-1:0]  log_size;
	} cfg_t;

	typedef struct packed {
		logic              load_wr;
		logic [ADDR_W-1:0] load_addr;
		logic              bf_rd;
		logic              bf_wr_j;
		logic              bf_wr_i;
		logic [LOG_W-1:0]  pass_k;
		logic [ADDR_W-1:0] bf_idx;
		logic              em_rd;
		logic              em_ld;
		logic [ADDR_W-1:0] em_addr;
		logic              em_last;
	} cmd_t;

	function automatic logic [LOG_W-1:0] sat_log(input logic [LOG_W-1:0] l);
		return (l > MAX_LOG) ? MAX_LOG : l;
	endfunction

	function automatic logic [WORD_W-1:0] ext_sample(input logic [SAMPLE_W-1:0] s);
		return {{(WORD_W - SAMPLE_WIDTH){s[SAMPLE_WIDTH-1]}}, s[SAMPLE_WIDTH-1:0]};
	endfunction

	// upper index of butterfly number idx in pass k: insert a one at bit k
	function automatic logic [ADDR_W-1:0] bf_upper(input logic [ADDR_W-1:0] idx,
			input logic [LOG_W-1:0] k);
		logic [ADDR_W-1:0] bit_k;
		logic [ADDR_W-1:0] low_mask;
		bit_k    = ADDR_W'(1) << k;
		low_mask = bit_k - ADDR_W'(1);
		return ((idx & ~low_mask) << 1) | bit_k | (idx & low_mask);
	endfunction

endpackage

// ===== src/whxoa_ctrl.sv =====
// sequencer for load, butterfly passes and emit of the walsh hadamard unit
`timescale 1ns / 1ps

module whxoa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  whxoa_pkg::cfg_t   cfg,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output whxoa_pkg::cmd_t   cmd
);

	typedef enum logic [6:0] {
		S_LOAD   = 7'b0000001,
		S_RD     = 7'b0000010,
		S_WRJ    = 7'b0000100,
		S_WRI    = 7'b0001000,
		S_EM_RD  = 7'b0010000,
		S_EM_LD  = 7'b0100000,
		S_EM_OUT = 7'b1000000
	} state_t;

	state_t                             state_q;
	logic [whxoa_pkg::CNT_W-1:0]        load_cnt_q;
	logic [whxoa_pkg::LOG_W-1:0]        pass_q;
	logic [whxoa_pkg::ADDR_W-1:0]       idx_q;

	logic [whxoa_pkg::LOG_W-1:0]        lg;
	logic [whxoa_pkg::CNT_W-1:0]        n;
	logic [whxoa_pkg::ADDR_W-1:0]       half_m1;
	logic [whxoa_pkg::ADDR_W-1:0]       last_idx;
	logic [whxoa_pkg::CNT_W-1:0]        load_idx;
	logic [whxoa_pkg::CNT_W-1:0]        load_next;
	logic                               load_done;
	logic                               in_accept;

	always_comb begin
		lg        = whxoa_pkg::sat_log(cfg.log_size);
		n         = whxoa_pkg::CNT_W'(1) << lg;
		half_m1   = whxoa_pkg::ADDR_W'((n >> 1) - whxoa_pkg::CNT_W'(1));
		last_idx  = whxoa_pkg::ADDR_W'(n - whxoa_pkg::CNT_W'(1));
		// a shrunk size drops the partial vector
		load_idx  = (load_cnt_q >= n) ? '0 : load_cnt_q;
		load_next = load_idx + whxoa_pkg::CNT_W'(1);
		load_done = (load_next >= n);
		in_accept = in_valid && (state_q == S_LOAD);
	end

	assign in_stall  = (state_q != S_LOAD);
	assign out_valid = (state_q == S_EM_OUT);

	always_comb begin
		cmd.load_wr   = in_accept;
		cmd.load_addr = load_idx[whxoa_pkg::ADDR_W-1:0];
		cmd.bf_rd     = (state_q == S_RD);
		cmd.bf_wr_j   = (state_q == S_WRJ);
		cmd.bf_wr_i   = (state_q == S_WRI);
		cmd.pass_k    = pass_q;
		cmd.bf_idx    = idx_q;
		cmd.em_rd     = (state_q == S_EM_RD);
		cmd.em_ld     = (state_q == S_EM_LD);
		cmd.em_addr   = idx_q;
		cmd.em_last   = (idx_q == last_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			load_cnt_q <= '0;
			pass_q     <= '0;
			idx_q      <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (load_done) begin
							load_cnt_q <= '0;
							pass_q     <= '0;
							idx_q      <= '0;
							state_q    <= (lg == '0) ? S_EM_RD : S_RD;
						end else begin
							load_cnt_q <= load_next;
						end
					end
				end
				S_RD: state_q <= S_WRJ;
				S_WRJ: state_q <= S_WRI;
				S_WRI: begin
					if (idx_q == half_m1) begin
						idx_q <= '0;
						if (pass_q == lg - whxoa_pkg::LOG_W'(1)) begin
							state_q <= S_EM_RD;
						end else begin
							pass_q  <= pass_q + whxoa_pkg::LOG_W'(1);
							state_q <= S_RD;
						end
					end else begin
						idx_q   <= idx_q + whxoa_pkg::ADDR_W'(1);
						state_q <= S_RD;
					end
				end
				S_EM_RD: state_q <= S_EM_LD;
				S_EM_LD: state_q <= S_EM_OUT;
				S_EM_OUT: begin
					if (!out_stall) begin
						if (idx_q == last_idx) begin
							idx_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							idx_q   <= idx_q + whxoa_pkg::ADDR_W'(1);
							state_q <= S_EM_RD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

// ===== src/whxoa_dp.sv =====
// work memory, butterfly unit and output register of the walsh hadamard unit
`timescale 1ns / 1ps

module whxoa_dp (
	input  logic                                 clk,
	input  whxoa_pkg::cfg_t                      cfg,
	input  whxoa_pkg::cmd_t                      cmd,
	input  logic [whxoa_pkg::SAMPLE_W-1:0]       sample,
	output logic signed [whxoa_pkg::WORD_W-1:0]  coeff,
	output logic                                 final_flag
);

	logic [whxoa_pkg::WORD_W-1:0] work_mem_q [whxoa_pkg::DEPTH];
	logic [whxoa_pkg::WORD_W-1:0] rd_a_q;
	logic [whxoa_pkg::WORD_W-1:0] rd_b_q;
	logic [whxoa_pkg::WORD_W-1:0] coeff_q;
	logic                         final_q;

	logic [whxoa_pkg::ADDR_W-1:0] i_addr;
	logic [whxoa_pkg::ADDR_W-1:0] j_addr;
	logic [whxoa_pkg::ADDR_W-1:0] addr_a;
	logic [whxoa_pkg::WORD_W-1:0] res_j;
	logic [whxoa_pkg::WORD_W-1:0] res_i;
	logic                         wr_en;
	logic [whxoa_pkg::ADDR_W-1:0] wr_addr;
	logic [whxoa_pkg::WORD_W-1:0] wr_data;
	logic [whxoa_pkg::LOG_W-1:0]  lg;
	logic [whxoa_pkg::WORD_W-1:0] bias;
	logic [whxoa_pkg::WORD_W-1:0] biased;
	logic [whxoa_pkg::WORD_W-1:0] quot;
	logic [whxoa_pkg::WORD_W-1:0] em_val;

	always_comb begin
		i_addr = whxoa_pkg::bf_upper(cmd.bf_idx, cmd.pass_k);
		j_addr = i_addr & ~(whxoa_pkg::ADDR_W'(1) << cmd.pass_k);
		addr_a = cmd.em_rd ? cmd.em_addr : j_addr;
	end

	// a is the lower element of the pair, b the upper
	always_comb begin
		res_j = rd_a_q;
		res_i = rd_b_q;
		case (cfg.mode)
			whxoa_pkg::MODE_XOR: begin
				res_j = rd_a_q + rd_b_q;
				res_i = rd_a_q - rd_b_q;
			end
			whxoa_pkg::MODE_OR: begin
				res_i = cfg.inverse ? (rd_b_q - rd_a_q) : (rd_b_q + rd_a_q);
			end
			whxoa_pkg::MODE_AND: begin
				res_j = cfg.inverse ? (rd_a_q - rd_b_q) : (rd_a_q + rd_b_q);
			end
			default: begin
				res_j = rd_a_q;
				res_i = rd_b_q;
			end
		endcase
	end

	always_comb begin
		wr_en = cmd.load_wr || cmd.bf_wr_j || cmd.bf_wr_i;
		if (cmd.load_wr) begin
			wr_addr = cmd.load_addr;
			wr_data = whxoa_pkg::ext_sample(sample);
		end else if (cmd.bf_wr_j) begin
			wr_addr = j_addr;
			wr_data = res_j;
		end else begin
			wr_addr = i_addr;
			wr_data = res_i;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			work_mem_q[wr_addr] <= wr_data;
		end
		if (cmd.bf_rd || cmd.em_rd) begin
			rd_a_q <= work_mem_q[addr_a];
		end
		if (cmd.bf_rd) begin
			rd_b_q <= work_mem_q[i_addr];
		end
	end

	// xor inverse: divide by n, truncating toward zero
	always_comb begin
		lg     = whxoa_pkg::sat_log(cfg.log_size);
		bias   = rd_a_q[whxoa_pkg::WORD_W-1] ?
			((whxoa_pkg::WORD_W'(1) << lg) - whxoa_pkg::WORD_W'(1)) : '0;
		biased = rd_a_q + bias;
		quot   = whxoa_pkg::WORD_W'($signed(biased) >>> lg);
		em_val = (cfg.mode == whxoa_pkg::MODE_XOR && cfg.inverse) ? quot : rd_a_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.em_ld) begin
			coeff_q <= em_val;
			final_q <= cmd.em_last;
		end
	end

	assign coeff      = $signed(coeff_q);
	assign final_flag = final_q;

endmodule

// ===== src/walsh_hadamard_xor_or_and_unit.sv =====
// top level of the walsh hadamard xor/or/and transform unit
`timescale 1ns / 1ps

// Collects n = 2^log_size samples (log_size saturates at 6), one per accepted item,
// then transforms the vector in place and returns n coefficients in index order
// with final_flag on the last. Each butterfly is one dual read, then one write for
// each element of the pair, because the work memory has a single write port. Each
// coefficient is emitted by a read, a load of the output register and a hand-out
// that waits out any output stall. Input is stalled from the last sample of a
// vector until its last coefficient has been taken. Registers (mode, inverse,
// log_size) are written through the plain write port.

module walsh_hadamard_xor_or_and_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_wr_en,
	input  logic [whxoa_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [whxoa_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [whxoa_pkg::SAMPLE_W-1:0]   sample,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [whxoa_pkg::WORD_W-1:0]     coeff,
	output logic                                    final_flag
);

	whxoa_pkg::cfg_t cfg_q;
	whxoa_pkg::cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= whxoa_pkg::MODE_XOR;
			cfg_q.inverse  <= 1'b0;
			cfg_q.log_size <= whxoa_pkg::LOG_SIZE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				whxoa_pkg::REG_MODE:     cfg_q.mode     <= cfg_data[whxoa_pkg::MODE_W-1:0];
				whxoa_pkg::REG_INVERSE:  cfg_q.inverse  <= cfg_data[0];
				whxoa_pkg::REG_LOG_SIZE: cfg_q.log_size <= cfg_data[whxoa_pkg::LOG_W-1:0];
				default: ;
			endcase
		end
	end

	whxoa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	whxoa_dp u_dp (
		.clk        (clk),
		.cfg        (cfg_q),
		.cmd        (cmd),
		.sample     (sample),
		.coeff      (coeff),
		.final_flag (final_flag)
	);

endmodule

// ===== src/whxoa_checker.sv =====
// port-level checker for the walsh hadamard unit and its bind
`timescale 1ns / 1ps
`include "walsh_hadamard_xor_or_and_unit_defines.svh"

module whxoa_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [whxoa_pkg::WORD_W-1:0] coeff,
	input logic                                final_flag
);

	// input side is held off while results are being handed out
	`WHXOA_ASSERT_IMP(a_no_load_during_emit, out_valid, in_stall)

	// each taken item is followed by a gap while the next one is fetched
	`WHXOA_ASSERT_NXT(a_gap_after_item, out_valid && !out_stall, !out_valid)

	// the vector closes: after the last item input opens again
	`WHXOA_ASSERT_NXT(a_reopen_after_final, out_valid && !out_stall && final_flag, !in_stall)

	`WHXOA_ASSERT_NXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(coeff) && $stable(final_flag))

endmodule

bind walsh_hadamard_xor_or_and_unit whxoa_checker u_whxoa_checker (.*);
